[design/battery_gauge_filter_percent_unit_defines.svh]
// Assertion macros for the battery gauge filter percent unit.
`ifndef BATTERY_GAUGE_FILTER_PERCENT_UNIT_DEFINES_SVH
`define BATTERY_GAUGE_FILTER_PERCENT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BGFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bgfp_pkg.sv]
// Shared types, constants and the voltage level table for the battery gauge.
package bgfp_pkg;

  localparam int ADC_W      = 12;
  localparam int OFFSET_W   = 17;
  localparam int VOLT_W     = 22;
  localparam int PCT_W      = 7;
  localparam int TBL_IDX_W  = 4;
  localparam int TABLE_SIZE = 16;
  localparam int TEN_BITS   = 4;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // adc * 5808 / 10 gives volts * 65536 for 3.3 * 11 / 4096 V per LSB
  localparam logic [MUL_B_W-1:0] CONV_GAIN     = 27'd5808;
  localparam logic [MUL_B_W-1:0] FILT_OLD_GAIN = 27'd9;
  // ceil(2^30 / 10): exact floor(x / 10) for any x below 2^26
  localparam logic [MUL_B_W-1:0] RECIP_10      = 27'd107374183;
  localparam int                 RECIP_SHIFT   = 30;
  localparam logic [MUL_A_W-1:0] ROUND_HALF    = 26'd5;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 17'd57016;
  localparam logic [VOLT_W-1:0]   LOAD_THRESHOLD = 22'd6554;
  localparam logic [7:0]          PCT_FULL       = 8'd100;

  typedef logic [TBL_IDX_W-1:0] tbl_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV1,
    ST_FILT,
    ST_FDIV,
    ST_SRCH,
    ST_TEN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_ADC,
    MUL_CONV,
    MUL_NINE,
    MUL_FILT
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     now_ld;
    logic     filt_ld_now;
    logic     filt_ld_div;
    logic     srch;
    logic     ten;
    logic     out_ld;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic filt_low;
    logic hit;
    logic idx_zero;
    logic idx_last;
    logic span_zero;
    logic bit_last;
  } stat_t;

  // descending breakpoints, volts * 65536; entries past ten repeat 9.0 V
  function automatic logic [VOLT_W-1:0] level_at(input tbl_idx_t idx);
    logic [VOLT_W-1:0] lvl;
    case (idx)
      4'd0:    lvl = 22'd786432;
      4'd1:    lvl = 22'd773325;
      4'd2:    lvl = 22'd753664;
      4'd3:    lvl = 22'd740557;
      4'd4:    lvl = 22'd727450;
      4'd5:    lvl = 22'd720896;
      4'd6:    lvl = 22'd714342;
      4'd7:    lvl = 22'd701235;
      4'd8:    lvl = 22'd688128;
      default: lvl = 22'd589824;
    endcase
    return lvl;
  endfunction

endpackage

[design/bgfp_mul.sv]
// Shared registered multiplier used for scaling, filtering and divide by ten.
module bgfp_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic [bgfp_pkg::MUL_A_W-1:0]     a,
  input  logic [bgfp_pkg::MUL_B_W-1:0]     b,
  output logic [bgfp_pkg::PROD_W-1:0]      prod
);

  logic [bgfp_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{bgfp_pkg::MUL_B_W{1'b0}}, a} * {{bgfp_pkg::MUL_A_W{1'b0}}, b};
    end
  end

  assign prod = prod_r;

endmodule

[design/bgfp_ctrl.sv]
// Sequencer for the shared multiplier, table search and tenths divide steps.
module bgfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  bgfp_pkg::stat_t    stat,
  output bgfp_pkg::ctrl_t    ctrl,
  output bgfp_pkg::state_t   state
);

  bgfp_pkg::state_t st_r;
  bgfp_pkg::state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bgfp_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bgfp_pkg::ST_IDLE: begin
        if (stat.in_valid) st_nxt = bgfp_pkg::ST_CONV;
      end
      bgfp_pkg::ST_CONV: st_nxt = bgfp_pkg::ST_DIV1;
      bgfp_pkg::ST_DIV1: begin
        st_nxt = stat.filt_low ? bgfp_pkg::ST_SRCH : bgfp_pkg::ST_FILT;
      end
      bgfp_pkg::ST_FILT: st_nxt = bgfp_pkg::ST_FDIV;
      bgfp_pkg::ST_FDIV: st_nxt = bgfp_pkg::ST_SRCH;
      bgfp_pkg::ST_SRCH: begin
        if (stat.hit) begin
          st_nxt = (stat.idx_zero || stat.span_zero) ? bgfp_pkg::ST_DONE : bgfp_pkg::ST_TEN;
        end else if (stat.idx_last) begin
          st_nxt = bgfp_pkg::ST_DONE;
        end
      end
      bgfp_pkg::ST_TEN: begin
        if (stat.bit_last) st_nxt = bgfp_pkg::ST_DONE;
      end
      bgfp_pkg::ST_DONE: begin
        if (stat.out_free) st_nxt = bgfp_pkg::ST_IDLE;
      end
      default: st_nxt = bgfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = bgfp_pkg::MUL_ADC;
    case (st_r)
      bgfp_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.mul_en   = stat.in_valid;
        ctrl.mul_sel  = bgfp_pkg::MUL_ADC;
      end
      bgfp_pkg::ST_CONV: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bgfp_pkg::MUL_CONV;
      end
      bgfp_pkg::ST_DIV1: begin
        ctrl.now_ld      = 1'b1;
        ctrl.filt_ld_now = stat.filt_low;
        ctrl.mul_en      = !stat.filt_low;
        ctrl.mul_sel     = bgfp_pkg::MUL_NINE;
      end
      bgfp_pkg::ST_FILT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bgfp_pkg::MUL_FILT;
      end
      bgfp_pkg::ST_FDIV: ctrl.filt_ld_div = 1'b1;
      bgfp_pkg::ST_SRCH: ctrl.srch = 1'b1;
      bgfp_pkg::ST_TEN:  ctrl.ten = 1'b1;
      bgfp_pkg::ST_DONE: ctrl.out_ld = stat.out_free;
      default: ctrl = '0;
    endcase
  end

  assign state = st_r;

endmodule

[design/battery_gauge_filter_percent_unit.sv]
// Battery gauge: ADC word to offset volts, IIR filtered volts and charge percent.
// Steps to out_valid: multiplier passes to scale and, unless the filter is low, filter;
//   then one table compare per breakpoint and 4 tenths divide steps.
// One word in flight; in_stall drops again the cycle after the result is registered.
// Pace is set by the single shared multiplier and the serial breakpoint search.
// Sync reset clears the filter to 0, sets the offset to 0.87 V and empties the output.
module battery_gauge_filter_percent_unit #(
  parameter int BREAKPOINTS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bgfp_pkg::OFFSET_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bgfp_pkg::ADC_W-1:0]    in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bgfp_pkg::VOLT_W-1:0]   out_voltage_now,
  output logic [bgfp_pkg::VOLT_W-1:0]   out_voltage_filtered,
  output logic [bgfp_pkg::PCT_W-1:0]    out_charge_percent
);

  `include "battery_gauge_filter_percent_unit_defines.svh"

  localparam int N     = (BREAKPOINTS > bgfp_pkg::TABLE_SIZE) ? bgfp_pkg::TABLE_SIZE
                                                              : BREAKPOINTS;
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
  localparam int VW    = bgfp_pkg::VOLT_W;
  localparam int AW    = bgfp_pkg::MUL_A_W;

  bgfp_pkg::ctrl_t  ctrl;
  bgfp_pkg::stat_t  stat;
  bgfp_pkg::state_t st;

  logic [AW-1:0]                 mul_a;
  logic [bgfp_pkg::MUL_B_W-1:0]  mul_b;
  logic [bgfp_pkg::PROD_W-1:0]   prod;

  logic [bgfp_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [VW-1:0]                 filt_r, filt_nxt;
  logic [VW-1:0]                 now_r, now_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]                 rem_r, rem_nxt;
  logic [AW-1:0]                 dvs_r, dvs_nxt;
  logic [bgfp_pkg::TEN_BITS-1:0] tq_r, tq_nxt;
  logic [7:0]                    seg_r, seg_nxt;
  logic [1:0]                    bit_r, bit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [VW-1:0]                 out_now_r, out_now_nxt;
  logic [VW-1:0]                 out_filt_r, out_filt_nxt;
  logic [bgfp_pkg::PCT_W-1:0]    out_pct_r, out_pct_nxt;

  logic [VW-1:0]    quot;
  logic [VW-1:0]    now_calc;
  logic [IDX_W-1:0] idx_prev;
  logic [VW-1:0]    lvl_cur;
  logic [VW-1:0]    lvl_prev;
  logic [VW-1:0]    diff;
  logic [VW-1:0]    span;
  logic [7:0]       seg_cnt;
  logic [7:0]       seg_val;
  logic [7:0]       pct_sum;
  logic             out_free;

  bgfp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .state (st)
  );

  bgfp_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    case (ctrl.mul_sel)
      bgfp_pkg::MUL_ADC: begin
        mul_a = AW'(in_adc_sample);
        mul_b = bgfp_pkg::CONV_GAIN;
      end
      bgfp_pkg::MUL_CONV: begin
        mul_a = prod[AW-1:0] + bgfp_pkg::ROUND_HALF;
        mul_b = bgfp_pkg::RECIP_10;
      end
      bgfp_pkg::MUL_NINE: begin
        mul_a = AW'(filt_r);
        mul_b = bgfp_pkg::FILT_OLD_GAIN;
      end
      bgfp_pkg::MUL_FILT: begin
        mul_a = prod[AW-1:0] + AW'(now_r) + bgfp_pkg::ROUND_HALF;
        mul_b = bgfp_pkg::RECIP_10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign quot     = prod[bgfp_pkg::RECIP_SHIFT +: VW];
  assign now_calc = quot + VW'(offset_r);

  assign idx_prev = idx_r - IDX_W'(1);
  assign lvl_cur  = bgfp_pkg::level_at(bgfp_pkg::tbl_idx_t'(idx_r));
  assign lvl_prev = bgfp_pkg::level_at(bgfp_pkg::tbl_idx_t'(idx_prev));
  assign diff     = filt_r - lvl_cur;
  assign span     = lvl_prev - lvl_cur;
  assign seg_cnt  = 8'(N) - 8'(idx_r);
  assign seg_val  = (seg_cnt << 3) + (seg_cnt << 1);
  assign pct_sum  = seg_r + 8'(tq_r);
  assign out_free = !out_valid_r || !out_stall;

  assign stat.in_valid  = in_valid;
  assign stat.out_free  = out_free;
  assign stat.filt_low  = filt_r < bgfp_pkg::LOAD_THRESHOLD;
  assign stat.hit       = filt_r > lvl_cur;
  assign stat.idx_zero  = idx_r == '0;
  assign stat.idx_last  = idx_r == IDX_W'(N - 1);
  assign stat.span_zero = span == '0;
  assign stat.bit_last  = bit_r == '0;

  always_comb begin
    offset_nxt    = cfg_wr_en ? cfg_wr_data : offset_r;
    filt_nxt      = filt_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    tq_nxt        = tq_r;
    seg_nxt       = seg_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_now_nxt   = out_now_r;
    out_filt_nxt  = out_filt_r;
    out_pct_nxt   = out_pct_r;

    if (ctrl.in_ready && in_valid) idx_nxt = '0;
    if (ctrl.now_ld) now_nxt = now_calc;
    if (ctrl.filt_ld_now) filt_nxt = now_calc;
    if (ctrl.filt_ld_div) filt_nxt = quot;

    if (ctrl.srch) begin
      if (stat.hit) begin
        tq_nxt = '0;
        if (stat.idx_zero) begin
          seg_nxt = bgfp_pkg::PCT_FULL;
        end else begin
          seg_nxt = seg_val;
          rem_nxt = (AW'(diff) << 3) + (AW'(diff) << 1);
          dvs_nxt = AW'(span) << 3;
          bit_nxt = 2'(bgfp_pkg::TEN_BITS - 1);
        end
      end else if (stat.idx_last) begin
        seg_nxt = '0;
        tq_nxt  = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end

    // restoring divide, one tenths bit per step
    if (ctrl.ten) begin
      if (rem_r >= dvs_r) begin
        rem_nxt = rem_r - dvs_r;
        tq_nxt  = {tq_r[bgfp_pkg::TEN_BITS-2:0], 1'b1};
      end else begin
        tq_nxt  = {tq_r[bgfp_pkg::TEN_BITS-2:0], 1'b0};
      end
      dvs_nxt = dvs_r >> 1;
      bit_nxt = bit_r - 2'd1;
    end

    if (ctrl.out_ld) begin
      out_valid_nxt = 1'b1;
      out_now_nxt   = now_r;
      out_filt_nxt  = filt_r;
      out_pct_nxt   = (pct_sum > bgfp_pkg::PCT_FULL) ? bgfp_pkg::PCT_W'(bgfp_pkg::PCT_FULL)
                                                     : pct_sum[bgfp_pkg::PCT_W-1:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= bgfp_pkg::OFFSET_RESET;
      filt_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      filt_r      <= filt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    tq_r       <= tq_nxt;
    seg_r      <= seg_nxt;
    bit_r      <= bit_nxt;
    out_now_r  <= out_now_nxt;
    out_filt_r <= out_filt_nxt;
    out_pct_r  <= out_pct_nxt;
  end

  assign in_stall             = !ctrl.in_ready;
  assign out_valid            = out_valid_r;
  assign out_voltage_now      = out_now_r;
  assign out_voltage_filtered = out_filt_r;
  assign out_charge_percent   = out_pct_r;

  `BGFP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `BGFP_ASSERT_NOW(a_tenths_bound, st == bgfp_pkg::ST_DONE, tq_r <= 4'd10, "tenths above ten")
  `BGFP_ASSERT_NOW(a_pct_range, out_valid, out_charge_percent <= 7'd100, "percent above 100")

endmodule
